FILE: hdl/fmbe_pkg.sv
package fmbe_pkg;

  localparam int unsigned CntW = 17;
  localparam int unsigned NumBase = 4;
  localparam int unsigned NumCfg = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgPrimary = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartA = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStartC = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgStartG = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStartT = 3'd4;

  localparam logic OpLoad = 1'b0;
  localparam logic OpExtend = 1'b1;

  typedef logic [CntW-1:0] cnt_t;
  typedef cnt_t [NumBase-1:0] cnt4_t;

  // Result of one occurrence count pass.
  typedef struct packed {
    logic done;
    cnt4_t cnt;
  } occ_res_t;

endpackage

FILE: hdl/fmbe_ram.sv
module fmbe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hdl/fmbe_occ.sv
// Occurrence counter: checkpoint read then one symbol per cycle walk.
// Shared for the k and l rows of an extension.
module fmbe_occ
  import fmbe_pkg::*;
#(
  parameter int unsigned SeqMax = 65536,
  parameter int unsigned OccInterval = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               zero_i,
  input  logic [$clog2(SeqMax):0]            n_i,
  output logic [$clog2(SeqMax/OccInterval)-1:0] ck_addr_o,
  input  fmbe_pkg::cnt4_t                    ck_data_i,
  output logic [$clog2(SeqMax)-1:0]          sym_addr_o,
  input  logic [1:0]                         sym_data_i,
  output fmbe_pkg::occ_res_t                 res_o
);

  localparam int unsigned PosW = $clog2(SeqMax);
  localparam int unsigned OffW = $clog2(OccInterval);

  typedef enum logic [2:0] {StIdle, StCk, StCkWait, StWalk, StDone} st_e;

  st_e st_q;
  logic [PosW:0] n_q, p_q;
  logic [PosW-1:0] nm1;
  logic [PosW-1:0] nq_m1;
  cnt4_t cnt_q;
  logic p_valid_q;

  assign nm1 = PosW'(n_i - 1'b1);
  // checkpoint address held from the latched count while the pass runs
  assign nq_m1 = PosW'(n_q - 1'b1);
  assign ck_addr_o = nq_m1[PosW-1:OffW];
  assign sym_addr_o = p_q[PosW-1:0];
  assign res_o.done = (st_q == StDone);
  assign res_o.cnt = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      n_q <= '0;
      p_q <= '0;
      p_valid_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      case (st_q)
        StIdle: begin
          if (start_i) begin
            if (zero_i) begin
              cnt_q <= '0;
              st_q <= StDone;
            end else begin
              n_q <= n_i;
              p_q <= {1'b0, nm1[PosW-1:OffW], {OffW{1'b0}}};
              st_q <= StCk;
            end
          end
        end
        StCk: st_q <= StCkWait;  // address presented, data next edge
        StCkWait: begin
          cnt_q <= ck_data_i;
          p_valid_q <= 1'b0;
          st_q <= StWalk;
        end
        StWalk: begin
          // pipelined: p_q addresses the symbol RAM, data arrives in the following cycle
          if (p_valid_q) begin
            cnt_q[sym_data_i] <= cnt_q[sym_data_i] + 1'b1;
          end
          if (p_q < n_q) begin
            p_q <= p_q + 1'b1;
            p_valid_q <= 1'b1;
          end else begin
            p_valid_q <= 1'b0;
            if (!p_valid_q) st_q <= StDone;
          end
        end
        StDone: st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: hdl/fm_index_bidirectional_extend_top.sv
// Bidirectional FM-index extension engine.
// Slave stream (s_axis_*): one transaction is either a load (store one BWT
// symbol at a position, ascending from zero after reset) or an extend of a
// bidirectional interval. Master stream (m_axis_*): an extend yields four
// child transactions for bases 0..3, tlast on the fourth. Loads yield none.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i write primary and the four base
// starts; write only while idle.
// Sequence: a load is accepted, then written to the RAMs. An extend is accepted,
// then runs two occurrence passes on the shared counter, each reading a
// checkpoint and walking the symbols of its block up to the last counted row,
// or skipping the walk when the row count is zero, then a size step, the
// chain steps and the output of the four children; the symbol RAM port (one
// symbol per cycle) sets the walk length.
// s_axis_tready is low while an item is in work or results are pending.
// A stalled receiver holds the current child: idx_q does not advance.
// Reset clears running counts, config registers and control; the symbol and
// checkpoint RAMs are not cleared and must be loaded before use.
module fm_index_bidirectional_extend_top
  import fmbe_pkg::*;
#(
  parameter int unsigned SeqMax = 65536,
  parameter int unsigned OccInterval = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fmbe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fmbe_pkg::CntW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] operation, [16:1] load_position, [18:17] load_symbol, [19] direction,
  // [36:20] fwd_start, [53:37] rev_start, [70:54] interval_size, pad to 72
  input  logic [71:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] child_base, [18:2] fwd_start_out, [35:19] rev_start_out,
  // [52:36] size_out, pad to 56
  output logic [55:0]                   m_axis_tdata,
  output logic                          m_axis_tlast
);

  localparam int unsigned PosW = $clog2(SeqMax);
  localparam int unsigned NumCk = SeqMax / OccInterval;
  localparam int unsigned CkW = $clog2(NumCk);
  localparam int unsigned OffW = $clog2(OccInterval);

  typedef enum logic [3:0] {
    StIdle, StLoad, StK, StKWait, StL, StLWait, StSize, StChain, StOut
  } st_e;

  st_e st_q;
  cnt_t primary_q;
  cnt4_t base_q, run_q, tk_q, tl_q, sz_q, sa_q, sb_q;
  logic back_q;
  cnt_t a_q, b_q, size_q;
  logic [1:0] idx_q;
  logic [1:0] ci_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primary_q <= '0;
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPrimary: primary_q <= cfg_data_i;
        CfgStartA: base_q[0] <= cfg_data_i;
        CfgStartC: base_q[1] <= cfg_data_i;
        CfgStartG: base_q[2] <= cfg_data_i;
        CfgStartT: base_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic in_op, in_dir;
  logic [15:0] in_pos;
  logic [1:0] in_sym;
  cnt_t in_fwd, in_rev, in_size;
  assign in_op = s_axis_tdata[0];
  assign in_pos = s_axis_tdata[16:1];
  assign in_sym = s_axis_tdata[18:17];
  assign in_dir = s_axis_tdata[19];
  assign in_fwd = s_axis_tdata[36:20];
  assign in_rev = s_axis_tdata[53:37];
  assign in_size = s_axis_tdata[70:54];

  logic in_acc;
  assign s_axis_tready = (st_q == StIdle);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic [PosW-1:0] ld_pos_q;
  logic [1:0] ld_sym_q;
  logic ld_ok_q;

  // occurrence row: row = a - 1 (+ size); 19-bit signed arithmetic
  logic [18:0] row;
  logic row_neg;
  logic [18:0] nrow;
  logic [PosW:0] n_sat;
  logic occ_zero;
  always_comb begin
    row = {2'b0, a_q} - 19'd1;
    if (st_q == StL) row = row + {2'b0, size_q};
    row_neg = row[18];
    nrow = row + 19'd1 - {18'b0, (row >= {2'b0, primary_q})};
    occ_zero = row_neg || (nrow == '0);
    n_sat = (nrow > 19'(SeqMax)) ? (PosW+1)'(SeqMax) : (PosW+1)'(nrow);
  end

  logic occ_start;
  occ_res_t occ_res;
  logic [CkW-1:0] ck_raddr;
  logic [PosW-1:0] sym_raddr;
  cnt4_t ck_rdata;
  logic [1:0] sym_rdata;
  assign occ_start = (st_q == StK) || (st_q == StL);

  fmbe_occ #(.SeqMax(SeqMax), .OccInterval(OccInterval)) u_occ (
    .clk_i, .rst_ni,
    .start_i(occ_start), .zero_i(occ_zero), .n_i(n_sat),
    .ck_addr_o(ck_raddr), .ck_data_i(ck_rdata),
    .sym_addr_o(sym_raddr), .sym_data_i(sym_rdata),
    .res_o(occ_res)
  );

  logic sym_we, ck_we;
  assign sym_we = (st_q == StLoad) && ld_ok_q;
  assign ck_we = sym_we && (ld_pos_q[OffW-1:0] == '0);

  fmbe_ram #(.Width(2), .Depth(SeqMax)) u_sym (
    .clk_i, .we_i(sym_we), .waddr_i(ld_pos_q), .wdata_i(ld_sym_q),
    .raddr_i(sym_raddr), .rdata_o(sym_rdata)
  );

  fmbe_ram #(.Width(NumBase*CntW), .Depth(NumCk)) u_ck (
    .clk_i, .we_i(ck_we), .waddr_i(ld_pos_q[PosW-1:OffW]), .wdata_i(run_q),
    .raddr_i(ck_raddr), .rdata_o(ck_rdata)
  );

  logic has_primary;
  logic [17:0] a_end;
  assign a_end = {1'b0, a_q} + {1'b0, size_q};
  assign has_primary = (a_q <= primary_q) && ({1'b0, primary_q} < a_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      run_q <= '0;
      m_axis_tvalid <= 1'b0;
      idx_q <= '0;
      ci_q <= '0;
    end else begin
      case (st_q)
        StIdle: begin
          if (in_acc) begin
            if (in_op == OpLoad) begin
              ld_pos_q <= PosW'(in_pos);
              ld_sym_q <= in_sym;
              ld_ok_q <= ({1'b0, in_pos} < 17'(SeqMax));
              st_q <= StLoad;
            end else begin
              back_q <= in_dir;
              a_q <= in_dir ? in_fwd : in_rev;
              b_q <= in_dir ? in_rev : in_fwd;
              size_q <= in_size;
              st_q <= StK;
            end
          end
        end
        StLoad: begin
          if (ld_ok_q) run_q[ld_sym_q] <= run_q[ld_sym_q] + 1'b1;
          st_q <= StIdle;
        end
        StK: st_q <= StKWait;
        StKWait: if (occ_res.done) begin
          tk_q <= occ_res.cnt;
          st_q <= StL;
        end
        StL: st_q <= StLWait;
        StLWait: if (occ_res.done) begin
          tl_q <= occ_res.cnt;
          st_q <= StSize;
        end
        StSize: begin
          for (int i = 0; i < NumBase; i++) begin
            sz_q[i] <= tl_q[i] - tk_q[i];
            sa_q[i] <= base_q[i] + 1'b1 + tk_q[i];
          end
          sb_q[3] <= b_q + {16'b0, has_primary};
          ci_q <= 2'd2;
          st_q <= StChain;
        end
        StChain: begin
          sb_q[ci_q] <= sb_q[ci_q + 2'd1] + sz_q[ci_q + 2'd1];
          if (ci_q == 2'd0) begin
            idx_q <= '0;
            m_axis_tvalid <= 1'b1;
            st_q <= StOut;
          end
          ci_q <= ci_q - 2'd1;
        end
        StOut: if (m_axis_tready) begin
          if (idx_q == 2'd3) begin
            m_axis_tvalid <= 1'b0;
            st_q <= StIdle;
          end
          idx_q <= idx_q + 2'd1;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tdata = {3'b0, sz_q[idx_q],
                         back_q ? sb_q[idx_q] : sa_q[idx_q],
                         back_q ? sa_q[idx_q] : sb_q[idx_q],
                         idx_q};
  assign m_axis_tlast = (idx_q == 2'd3);

endmodule
